FILE: sv/rcdk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcdk_pkg
// Shared types, constants and calendar helpers for the calendar date keeper.
// ----------------------------------------------------------------------------
package rcdk_pkg;

    localparam logic [1:0]  FUNC_TICK = 2'd0;
    localparam logic [1:0]  FUNC_SET  = 2'd1;
    localparam logic [1:0]  FUNC_READ = 2'd2;

    localparam logic [31:0] DAY_SECONDS  = 32'd86400;
    localparam logic [16:0] HOUR_SECONDS = 17'd3600;
    localparam logic [16:0] MIN_SECONDS  = 17'd60;
    localparam logic [13:0] GREG_CYCLE   = 14'd400;
    localparam logic [13:0] YEAR_MAX     = 14'h3FFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic tick;
        logic set;
        logic step_mod;
        logic step_day;
        logic load_work;
        logic step_hour;
        logic step_min;
        logic calc_wd;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ymod_ge_cycle;
        logic cnt_ge_day;
        logic work_ge_hour;
        logic work_ge_min;
    } sts_t;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        year_inc;
    } date_t;

    // Two BCD nibbles taken at face value.
    function automatic logic [6:0] bcd_to_bin(input logic [6:0] v);
        logic [6:0] hi;
        hi = {4'd0, v[6:4]};
        return 7'((hi << 3) + (hi << 1) + {3'd0, v[3:0]});
    endfunction

    // Binary below sixty to two BCD digits.
    function automatic logic [6:0] bin_to_bcd60(input logic [5:0] v);
        logic [2:0] tens;
        logic [5:0] rest;
        if (v >= 6'd50)      tens = 3'd5;
        else if (v >= 6'd40) tens = 3'd4;
        else if (v >= 6'd30) tens = 3'd3;
        else if (v >= 6'd20) tens = 3'd2;
        else if (v >= 6'd10) tens = 3'd1;
        else                 tens = 3'd0;
        rest = 6'(v - 6'(tens) * 6'd10);
        return {tens, rest[3:0]};
    endfunction

    // Leap rule from the year taken modulo 400.
    function automatic logic leap_mod(input logic [8:0] m);
        return (m[1:0] == 2'd0) && (m != 9'd100) && (m != 9'd200) && (m != 9'd300);
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] r;
        unique case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Advance a date by one day. Unknown months hold.
    function automatic date_t next_date(input logic [13:0] y, input logic [3:0] m,
                                        input logic [4:0] d, input logic leap);
        date_t r;
        r.year     = y;
        r.month    = m;
        r.day      = d;
        r.year_inc = 1'b0;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12:
            begin
                if (d < 5'd31) begin
                    r.day = 5'(d + 5'd1);
                end else if (m != 4'd12) begin
                    r.month = 4'(m + 4'd1);
                    r.day   = 5'd1;
                end else begin
                    r.month    = 4'd1;
                    r.day      = 5'd1;
                    r.year     = 14'(y + 14'd1);
                    r.year_inc = 1'b1;
                end
            end
            4'd4, 4'd6, 4'd9, 4'd11:
            begin
                if (d < 5'd30) begin
                    r.day = 5'(d + 5'd1);
                end else begin
                    r.month = 4'(m + 4'd1);
                    r.day   = 5'd1;
                end
            end
            4'd2:
            begin
                if (d < 5'd28) begin
                    r.day = 5'(d + 5'd1);
                end else if (d == 5'd28) begin
                    if (leap) begin
                        r.day = 5'd29;
                    end else begin
                        r.month = 4'd3;
                        r.day   = 5'd1;
                    end
                end else if (d == 5'd29) begin
                    r.month = 4'd3;
                    r.day   = 5'd1;
                end
            end
            default:
            begin
                r.year = y;
            end
        endcase
        return r;
    endfunction

    // Residue modulo seven by folding octal digits (8 is 1 modulo 7).
    function automatic logic [2:0] mod7(input logic [17:0] v);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [2:0] s3;
        s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9])
           + 6'(v[14:12]) + 6'(v[17:15]);
        s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
        s3 = 3'(s2[2:0] + 3'(s2[3]));
        return (s3 == 3'd7) ? 3'd0 : s3;
    endfunction

endpackage
`default_nettype wire

FILE: sv/rtc_calendar_date_keeper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_calendar_date_keeper
// Seconds counter with a Gregorian date, weekday and BCD time on read.
// ----------------------------------------------------------------------------
// Channel   Handshake             Word
// input     in_valid / in_ready   func, set_year .. set_second_bcd
// output    out_valid / out_ready out_year .. out_weekday
//
// A set loads the fields, then reduces the year modulo 400 in steps of 400
// years. A read splits off the elapsed days in the counter one at a time, then
// the hours and minutes of the remainder, then forms the weekday.
// Reset loads 2000-01-01 00:00:00. The output register holds a result until
// taken; ticks and sets go on meanwhile, a finishing read waits for it.
// ----------------------------------------------------------------------------
module rtc_calendar_date_keeper (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  func,
    input  wire logic [13:0] set_year,
    input  wire logic [3:0]  set_month,
    input  wire logic [4:0]  set_day,
    input  wire logic [5:0]  set_hour_bcd,
    input  wire logic [6:0]  set_minute_bcd,
    input  wire logic [6:0]  set_second_bcd,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [13:0]      out_year,
    output logic [3:0]       out_month,
    output logic [4:0]       out_day,
    output logic [5:0]       out_hour_bcd,
    output logic [6:0]       out_minute_bcd,
    output logic [6:0]       out_second_bcd,
    output logic [2:0]       out_weekday
);
    import rcdk_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rcdk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rcdk_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .set_year       (set_year),
        .set_month      (set_month),
        .set_day        (set_day),
        .set_hour_bcd   (set_hour_bcd),
        .set_minute_bcd (set_minute_bcd),
        .set_second_bcd (set_second_bcd),
        .out_year       (out_year),
        .out_month      (out_month),
        .out_day        (out_day),
        .out_hour_bcd   (out_hour_bcd),
        .out_minute_bcd (out_minute_bcd),
        .out_second_bcd (out_second_bcd),
        .out_weekday    (out_weekday)
    );

`ifndef SYNTHESIS
    // A result is formed only after all whole days are split off.
    a_days_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !sts.cnt_ge_day)
        else $error("result formed with whole days left in counter");

    // The year residue is reduced before any day step or result.
    a_ymod_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out || cmd.step_day) |-> !sts.ymod_ge_cycle)
        else $error("year residue not reduced");

    // A read passes through the day, hour and minute states first, so no result right after acceptance.
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !cmd.load_out)
        else $error("result formed the cycle after acceptance");
`endif

endmodule
`default_nettype wire

FILE: sv/rcdk_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcdk_ctrl
// Sequencer for set, tick and read words, plus the result valid flag.
// ----------------------------------------------------------------------------
module rcdk_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [1:0]    func,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire rcdk_pkg::sts_t sts,
    output rcdk_pkg::cmd_t     cmd
);
    import rcdk_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_DAYS = 3'd2;
    localparam logic [2:0] S_HOUR = 3'd3;
    localparam logic [2:0] S_MINS = 3'd4;
    localparam logic [2:0] S_WD1  = 3'd5;
    localparam logic [2:0] S_WD2  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept) begin
                    if (func == FUNC_TICK) begin
                        cmd.tick = 1'b1;
                    end else if (func == FUNC_SET) begin
                        cmd.set    = 1'b1;
                        state_next = S_MOD;
                    end else if (func == FUNC_READ) begin
                        state_next = S_DAYS;
                    end
                end
            end
            S_MOD:
            begin
                if (sts.ymod_ge_cycle) cmd.step_mod = 1'b1;
                else                   state_next   = S_IDLE;
            end
            S_DAYS:
            begin
                if (sts.cnt_ge_day) begin
                    cmd.step_day = 1'b1;
                end else begin
                    cmd.load_work = 1'b1;
                    state_next    = S_HOUR;
                end
            end
            S_HOUR:
            begin
                if (sts.work_ge_hour) cmd.step_hour = 1'b1;
                else                  state_next    = S_MINS;
            end
            S_MINS:
            begin
                if (sts.work_ge_min) begin
                    cmd.step_min = 1'b1;
                end else begin
                    cmd.calc_wd = 1'b1;
                    state_next  = S_WD1;
                end
            end
            S_WD1:
            begin
                state_next = S_WD2;
            end
            S_WD2:
            begin
                // Wait here while the previous result is still held.
                if (!out_valid_reg || out_ready) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/rcdk_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcdk_datapath
// Seconds counter, date registers, split units and result registers.
// ----------------------------------------------------------------------------
module rcdk_datapath (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire rcdk_pkg::cmd_t cmd,
    output rcdk_pkg::sts_t      sts,
    input  wire logic [13:0]    set_year,
    input  wire logic [3:0]     set_month,
    input  wire logic [4:0]     set_day,
    input  wire logic [5:0]     set_hour_bcd,
    input  wire logic [6:0]     set_minute_bcd,
    input  wire logic [6:0]     set_second_bcd,
    output logic [13:0]         out_year,
    output logic [3:0]          out_month,
    output logic [4:0]          out_day,
    output logic [5:0]          out_hour_bcd,
    output logic [6:0]          out_minute_bcd,
    output logic [6:0]          out_second_bcd,
    output logic [2:0]          out_weekday
);
    import rcdk_pkg::*;

    logic [31:0] count_reg;
    logic [13:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic [13:0] ymod_reg;
    logic [16:0] work_reg;
    logic [5:0]  hour_reg;
    logic [6:0]  min_reg;
    logic [17:0] wd_sum_reg;

    logic [13:0] out_year_reg;
    logic [3:0]  out_month_reg;
    logic [4:0]  out_day_reg;
    logic [5:0]  out_hour_reg;
    logic [6:0]  out_min_reg;
    logic [6:0]  out_sec_reg;
    logic [2:0]  out_wd_reg;

    date_t       nd;
    logic        leap;
    logic [31:0] set_secs;
    logic [8:0]  r400;
    logic [1:0]  cent;
    logic [17:0] wd_sum;
    logic [13:0] ymod_inc;

    assign leap = leap_mod(ymod_reg[8:0]);
    assign nd   = next_date(year_reg, month_reg, day_reg, leap);

    // Year modulo 400 follows the year; the 14-bit wrap lands on zero.
    assign ymod_inc = (year_reg == YEAR_MAX) ? 14'd0 :
                      (ymod_reg == 14'd399) ? 14'd0 : 14'(ymod_reg + 14'd1);

    // Time of day loaded on set.
    assign set_secs = 32'(bcd_to_bin({1'b0, set_hour_bcd})) * 32'd3600
                    + 32'(bcd_to_bin(set_minute_bcd)) * 32'd60
                    + 32'(bcd_to_bin(set_second_bcd));

    // Weekday sum over the last year taken modulo 400.
    always_comb
    begin
        r400 = (ymod_reg[8:0] == 9'd0) ? 9'd399 : 9'(ymod_reg[8:0] - 9'd1);
        if (r400 >= 9'd300)      cent = 2'd3;
        else if (r400 >= 9'd200) cent = 2'd2;
        else if (r400 >= 9'd100) cent = 2'd1;
        else                     cent = 2'd0;
        wd_sum = 18'(18'(r400) * 18'd365) + 18'(r400[8:2]) - 18'(cent)
               + 18'(month_start(month_reg))
               + 18'(leap && (month_reg > 4'd2)) + 18'(day_reg);
    end

    assign sts.ymod_ge_cycle = (ymod_reg >= GREG_CYCLE);
    assign sts.cnt_ge_day    = (count_reg >= DAY_SECONDS);
    assign sts.work_ge_hour  = (work_reg >= HOUR_SECONDS);
    assign sts.work_ge_min   = (work_reg >= MIN_SECONDS);

    // Counter and date state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= 32'd0;
            year_reg  <= 14'd2000;
            month_reg <= 4'd1;
            day_reg   <= 5'd1;
            ymod_reg  <= 14'd0;
        end else begin
            if (cmd.tick) begin
                count_reg <= 32'(count_reg + 32'd1);
            end
            if (cmd.set) begin
                count_reg <= set_secs;
                year_reg  <= set_year;
                month_reg <= set_month;
                day_reg   <= set_day;
                ymod_reg  <= set_year;
            end
            if (cmd.step_mod) begin
                ymod_reg <= 14'(ymod_reg - GREG_CYCLE);
            end
            if (cmd.step_day) begin
                count_reg <= 32'(count_reg - DAY_SECONDS);
                year_reg  <= nd.year;
                month_reg <= nd.month;
                day_reg   <= nd.day;
                if (nd.year_inc) ymod_reg <= ymod_inc;
            end
        end
    end

    // Time-of-day split and weekday sum.
    always_ff @(posedge clk)
    begin
        if (cmd.load_work) begin
            work_reg <= count_reg[16:0];
            hour_reg <= 6'd0;
            min_reg  <= 7'd0;
        end
        if (cmd.step_hour) begin
            work_reg <= 17'(work_reg - HOUR_SECONDS);
            hour_reg <= (hour_reg[3:0] == 4'd9) ? {2'(hour_reg[5:4] + 2'd1), 4'd0}
                                                : 6'(hour_reg + 6'd1);
        end
        if (cmd.step_min) begin
            work_reg <= 17'(work_reg - MIN_SECONDS);
            min_reg  <= (min_reg[3:0] == 4'd9) ? {3'(min_reg[6:4] + 3'd1), 4'd0}
                                               : 7'(min_reg + 7'd1);
        end
        if (cmd.calc_wd) begin
            wd_sum_reg <= wd_sum;
        end
    end

    // Result word.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out) begin
            out_year_reg  <= year_reg;
            out_month_reg <= month_reg;
            out_day_reg   <= day_reg;
            out_hour_reg  <= hour_reg;
            out_min_reg   <= min_reg;
            out_sec_reg   <= bin_to_bcd60(work_reg[5:0]);
            out_wd_reg    <= mod7(wd_sum_reg);
        end
    end

    assign out_year       = out_year_reg;
    assign out_month      = out_month_reg;
    assign out_day        = out_day_reg;
    assign out_hour_bcd   = out_hour_reg;
    assign out_minute_bcd = out_min_reg;
    assign out_second_bcd = out_sec_reg;
    assign out_weekday    = out_wd_reg;

endmodule
`default_nettype wire

FILE: tb/sv/rtc_calendar_date_keeper_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_calendar_date_keeper_test
// Drives tick, set and read words into the calendar date keeper. A directed
// table covers field extremes, odd dates and BCD digits. A random run follows.
// Every read result is checked against a local calendar predictor or a typed expectation.
// ----------------------------------------------------------------------------
module rtc_calendar_date_keeper_test;
    import rcdk_pkg::*;

    localparam logic [1:0] FUNC_NOP = 2'd3;

    // One date and time, as returned by a read.
    typedef struct {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [5:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [2:0]  weekday;
    } calendar_t;

    // One input word, with an optional typed expectation.
    typedef struct {
        logic [1:0]  fn;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [5:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        bit          typed;
        calendar_t   want;
    } word_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [13:0] set_year;
    logic [3:0]  set_month;
    logic [4:0]  set_day;
    logic [5:0]  set_hour_bcd;
    logic [6:0]  set_minute_bcd;
    logic [6:0]  set_second_bcd;
    logic        out_valid;
    logic        out_ready;
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [5:0]  out_hour_bcd;
    logic [6:0]  out_minute_bcd;
    logic [6:0]  out_second_bcd;
    logic [2:0]  out_weekday;

    // Predicted clock state.
    logic [31:0] pred_seconds;
    logic [13:0] pred_year;
    logic [3:0]  pred_month;
    logic [4:0]  pred_day;

    calendar_t   pending_reads[$];
    int          mismatch_count;
    bit          stimulus_done;
    bit          quiet_phase;

    rtc_calendar_date_keeper dut (.*);

    // Clock and limit.
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic bit is_leap(input int unsigned y);
        if (y % 4 != 0) return 1'b0;
        if (y % 100 != 0) return 1'b1;
        return (y % 400) == 0;
    endfunction

    function automatic int unsigned bcd_value(input logic [6:0] v);
        return v[6:4] * 10 + v[3:0];
    endfunction

    function automatic logic [6:0] to_bcd(input int unsigned v);
        return 7'(((v / 10) << 4) + (v % 10));
    endfunction

    function automatic logic [2:0] day_of_week(input int unsigned y, input int unsigned m,
                                               input int unsigned d);
        int unsigned       prior;
        int unsigned       count;
        int unsigned       offs[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
        if (y == 0) y = 400;
        prior = y - 1;
        count = prior * 365 + prior / 4 - prior / 100 + prior / 400;
        if (m >= 1 && m <= 12) count += offs[m - 1];
        if (is_leap(y) && m > 2) count += 1;
        count += d;
        return 3'(count % 7);
    endfunction

    // Move the predicted date forward by one day; unknown months hold.
    task automatic roll_one_day();
        case (pred_month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12:
            begin
                if (pred_day < 31) begin
                    pred_day = 5'(pred_day + 5'd1);
                end else if (pred_month != 12) begin
                    pred_month = 4'(pred_month + 4'd1);
                    pred_day   = 5'd1;
                end else begin
                    pred_month = 4'd1;
                    pred_day   = 5'd1;
                    pred_year  = 14'(pred_year + 14'd1);
                end
            end
            4'd4, 4'd6, 4'd9, 4'd11:
            begin
                if (pred_day < 30) begin
                    pred_day = 5'(pred_day + 5'd1);
                end else begin
                    pred_month = 4'(pred_month + 4'd1);
                    pred_day   = 5'd1;
                end
            end
            4'd2:
            begin
                if (pred_day < 28) begin
                    pred_day = 5'(pred_day + 5'd1);
                end else if (pred_day == 28) begin
                    if (is_leap(pred_year)) begin
                        pred_day = 5'd29;
                    end else begin
                        pred_month = 4'd3;
                        pred_day   = 5'd1;
                    end
                end else if (pred_day == 29) begin
                    pred_month = 4'd3;
                    pred_day   = 5'd1;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Apply one accepted word to the predicted state and queue any read result.
    task automatic apply_word(input word_t w);
        calendar_t   r;
        int unsigned days;
        int unsigned rest;
        case (w.fn)
            FUNC_TICK:
            begin
                pred_seconds = pred_seconds + 1;
            end
            FUNC_SET:
            begin
                pred_year    = w.year;
                pred_month   = w.month;
                pred_day     = w.day;
                pred_seconds = bcd_value({1'b0, w.hour}) * 3600 + bcd_value(w.minute) * 60
                             + bcd_value(w.second);
            end
            FUNC_READ:
            begin
                days = pred_seconds / 86400;
                rest = pred_seconds % 86400;
                for (int unsigned i = 0; i < days; i++) roll_one_day();
                pred_seconds = rest;
                r.year    = pred_year;
                r.month   = pred_month;
                r.day     = pred_day;
                r.hour    = 6'(to_bcd(rest / 3600));
                r.minute  = to_bcd((rest % 3600) / 60);
                r.second  = to_bcd(rest % 60);
                r.weekday = day_of_week(pred_year, pred_month, pred_day);
                pending_reads.push_back(w.typed ? w.want : r);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // Mostly no gap, sometimes short, rarely long; none in a quiet phase.
    function automatic int pick_gap();
        int r;
        if (quiet_phase) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Send one word, wait for acceptance, then update the predictor.
    task automatic send_word(input word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        func           <= w.fn;
        set_year       <= w.year;
        set_month      <= w.month;
        set_day        <= w.day;
        set_hour_bcd   <= w.hour;
        set_minute_bcd <= w.minute;
        set_second_bcd <= w.second;
        do @(posedge clk); while (!in_ready);
        apply_word(w);
        @(negedge clk);
    endtask

    function automatic word_t make_word(input logic [1:0] fn, input int unsigned y,
                                        input int unsigned m, input int unsigned d,
                                        input logic [5:0] h, input logic [6:0] mi,
                                        input logic [6:0] s);
        word_t w;
        w.fn     = fn;
        w.year   = 14'(y);
        w.month  = 4'(m);
        w.day    = 5'(d);
        w.hour   = h;
        w.minute = mi;
        w.second = s;
        w.typed  = 1'b0;
        w.want   = '{default: '0};
        return w;
    endfunction

    function automatic word_t typed_read(input calendar_t c);
        word_t w;
        w       = make_word(FUNC_READ, 0, 0, 0, 6'h00, 7'h00, 7'h00);
        w.typed = 1'b1;
        w.want  = c;
        return w;
    endfunction

    // Random word: mostly ticks and reads, valid sets, a few wild sets and no-ops.
    function automatic word_t random_word();
        int          r;
        int unsigned m;
        int unsigned last;
        r = $urandom_range(0, 99);
        if (r < 45) return make_word(FUNC_TICK, $urandom, $urandom, $urandom,
                                     6'($urandom), 7'($urandom), 7'($urandom));
        if (r < 75) return make_word(FUNC_READ, $urandom, $urandom, $urandom,
                                     6'($urandom), 7'($urandom), 7'($urandom));
        if (r < 80) return make_word(FUNC_NOP, $urandom, $urandom, $urandom,
                                     6'($urandom), 7'($urandom), 7'($urandom));
        if (r < 88) return make_word(FUNC_SET, $urandom_range(0, 16383), $urandom_range(0, 15),
                                     $urandom_range(0, 31), 6'($urandom), 7'($urandom),
                                     7'($urandom));
        // Well-formed set, often near the end of a day or month.
        m    = $urandom_range(1, 12);
        last = (m == 2) ? 29 : (m == 4 || m == 6 || m == 9 || m == 11) ? 30 : 31;
        return make_word(FUNC_SET, $urandom_range(1, 9999), m,
                         $urandom_range(0, 1) ? last - $urandom_range(0, 2)
                                              : $urandom_range(1, last),
                         $urandom_range(0, 1) ? 6'h23 : 6'(to_bcd($urandom_range(0, 23))),
                         $urandom_range(0, 1) ? 7'h59 : to_bcd($urandom_range(0, 59)),
                         $urandom_range(0, 1) ? to_bcd($urandom_range(50, 59))
                                              : to_bcd($urandom_range(0, 59)));
    endfunction

    // Output side: random back-pressure, changed at the falling edge.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet_phase || $urandom_range(0, 99) < 70) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b0;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                    : $urandom_range(1, 3)) @(negedge clk);
            end
        end
    end

    // Compare each accepted result word with the oldest expected read.
    always @(posedge clk)
    begin
        calendar_t e;
        if (rst_n && out_valid && out_ready) begin
            if (pending_reads.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                e = pending_reads.pop_front();
                if (out_year !== e.year) report_mismatch("year", out_year, e.year);
                if (out_month !== e.month) report_mismatch("month", out_month, e.month);
                if (out_day !== e.day) report_mismatch("day", out_day, e.day);
                if (out_hour_bcd !== e.hour) report_mismatch("hour", out_hour_bcd, e.hour);
                if (out_minute_bcd !== e.minute)
                    report_mismatch("minute", out_minute_bcd, e.minute);
                if (out_second_bcd !== e.second)
                    report_mismatch("second", out_second_bcd, e.second);
                if (out_weekday !== e.weekday)
                    report_mismatch("weekday", out_weekday, e.weekday);
            end
        end
    end

    // Stimulus.
    initial
    begin
        word_t directed[$];
        int    waited;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        func           = FUNC_TICK;
        set_year       = '0;
        set_month      = '0;
        set_day        = '0;
        set_hour_bcd   = '0;
        set_minute_bcd = '0;
        set_second_bcd = '0;
        mismatch_count = 0;
        stimulus_done  = 1'b0;
        quiet_phase    = 1'b0;
        pred_seconds   = 0;
        pred_year      = 2000;
        pred_month     = 1;
        pred_day       = 1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset state, then the last second of year 9999 rolling over.
        directed.push_back(typed_read('{14'd2000, 4'd1, 5'd1, 6'h00, 7'h00, 7'h00, 3'd6}));
        directed.push_back(make_word(FUNC_SET, 9999, 12, 31, 6'h23, 7'h59, 7'h59));
        directed.push_back(make_word(FUNC_TICK, 0, 0, 0, 6'h00, 7'h00, 7'h00));
        directed.push_back(typed_read('{14'd10000, 4'd1, 5'd1, 6'h00, 7'h00, 7'h00, 3'd6}));
        // Year counter wraps to the proleptic year zero.
        directed.push_back(make_word(FUNC_SET, 16383, 12, 31, 6'h23, 7'h59, 7'h59));
        directed.push_back(make_word(FUNC_TICK, 0, 0, 0, 6'h00, 7'h00, 7'h00));
        directed.push_back(make_word(FUNC_READ, 0, 0, 0, 6'h00, 7'h00, 7'h00));
        // Leap and non-leap Februaries, with non-decimal digits spilling into days.
        directed.push_back(make_word(FUNC_SET, 1900, 2, 28, 6'h3F, 7'h7F, 7'h7F));
        directed.push_back(make_word(FUNC_READ, 0, 0, 0, 6'h00, 7'h00, 7'h00));
        directed.push_back(make_word(FUNC_SET, 2000, 2, 28, 6'h3F, 7'h00, 7'h00));
        directed.push_back(make_word(FUNC_READ, 0, 0, 0, 6'h00, 7'h00, 7'h00));
        directed.push_back(make_word(FUNC_SET, 0, 2, 28, 6'h24, 7'h00, 7'h00));
        directed.push_back(make_word(FUNC_READ, 0, 0, 0, 6'h00, 7'h00, 7'h00));
        // February past day 29 holds; unknown months hold.
        directed.push_back(make_word(FUNC_SET, 2024, 2, 31, 6'h3F, 7'h00, 7'h00));
        directed.push_back(make_word(FUNC_READ, 0, 0, 0, 6'h00, 7'h00, 7'h00));
        directed.push_back(make_word(FUNC_SET, 2024, 0, 15, 6'h30, 7'h00, 7'h00));
        directed.push_back(make_word(FUNC_READ, 0, 0, 0, 6'h00, 7'h00, 7'h00));
        directed.push_back(make_word(FUNC_SET, 2024, 15, 31, 6'h30, 7'h00, 7'h00));
        directed.push_back(make_word(FUNC_READ, 0, 0, 0, 6'h00, 7'h00, 7'h00));
        // Day zero and a 30-day month past its end; no-op leaves things alone.
        directed.push_back(make_word(FUNC_SET, 1, 4, 0, 6'h24, 7'h00, 7'h00));
        directed.push_back(make_word(FUNC_NOP, 16383, 15, 31, 6'h3F, 7'h7F, 7'h7F));
        directed.push_back(make_word(FUNC_READ, 0, 0, 0, 6'h00, 7'h00, 7'h00));
        directed.push_back(make_word(FUNC_SET, 1, 11, 31, 6'h24, 7'h00, 7'h00));
        directed.push_back(make_word(FUNC_READ, 0, 0, 0, 6'h00, 7'h00, 7'h00));

        foreach (directed[i]) send_word(directed[i]);
        for (int i = 0; i < 450; i++) begin
            if (i % 60 == 0) quiet_phase = ($urandom_range(0, 2) == 0);
            send_word(random_word());
        end
        in_valid      <= 1'b0;
        quiet_phase    = 1'b0;
        stimulus_done  = 1'b1;

        // Drain, then give the block time for anything unexpected.
        waited = 0;
        while (pending_reads.size() != 0 && waited < 200000) begin
            @(negedge clk);
            waited++;
        end
        repeat (200) @(negedge clk);
        if (mismatch_count == 0 && pending_reads.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/rcdk_pkg.sv
sv/rcdk_ctrl.sv
sv/rcdk_datapath.sv
sv/rtc_calendar_date_keeper.sv
tb/sv/rtc_calendar_date_keeper_test.sv
